[hw/rtl/tsev_pkg.sv]
// Package for the timed servo event scheduler.
// Opcodes, status codes, register indexes, field widths and reset values.
// No dependencies.
package tsev_pkg;

   localparam int unsigned TimeW   = 52;
   localparam int unsigned SecW    = 32;
   localparam int unsigned UsW     = 20;
   localparam int unsigned PulseW  = 8;
   localparam int unsigned HoldW   = 24;
   localparam int unsigned CountW  = 7;
   localparam int unsigned ReqDataW = 160;
   localparam int unsigned RspDataW = 72;

   localparam int unsigned DefQueueDepth = 64;

   localparam logic [TimeW-1:0]  US_PER_S        = TimeW'(1000000);
   localparam logic [PulseW-1:0] OPEN_PULSE_RST  = PulseW'(105);
   localparam logic [PulseW-1:0] CLOSE_PULSE_RST = PulseW'(180);
   localparam logic [HoldW-1:0]  HOLD_RST        = HoldW'(500000);

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [1:0] REG_OPEN_PULSE  = 2'd0;
   localparam logic [1:0] REG_CLOSE_PULSE = 2'd1;
   localparam logic [1:0] REG_POWER_HOLD  = 2'd2;

endpackage

[hw/rtl/timed_servo_event_scheduler.sv]
// Timed servo event scheduler: event store, scan sequencer and servo/power state.
// Depends on tsev_pkg.
//
// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | tuser: operation; tdata: open, close, now times
// rsp     | out | rsp_tvalid/rsp_tready  | tuser: status; tdata: flags, width, count, armed
// csr     | in  | csr_we                 | csr_index, csr_wdata
//
// An add, and a tick that opens, make one scan of the event memory, one entry per cycle
// through its registered read port; other ticks, clear and unused codes do not scan.
// Three time conversions share one 32x20 multiplier. One transaction at a time:
// req_tready is low from accept until the response transaction completes.
// Synchronous active-high reset clears valid bits and control state; memories are not cleared.
module timed_servo_event_scheduler #(
   parameter int unsigned QUEUE_DEPTH = tsev_pkg::DefQueueDepth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // open_s, open_us, close_s, close_us, now_s, now_us, 4 bits zero
   input  logic [tsev_pkg::ReqDataW-1:0]   req_tdata,
   // operation
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // open_fired, close_fired, power_enable, pulse_width, entry_count, armed_open_time, 2 zero
   output logic [tsev_pkg::RspDataW-1:0]   rsp_tdata,
   // status
   output logic [1:0]                      rsp_tuser,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [tsev_pkg::HoldW-1:0]      csr_wdata
);
   import tsev_pkg::*;

   localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CVT, S_OPEN, S_SCAN, S_COMMIT, S_REARM, S_CLOSE, S_POWER, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [155:0] req_ff, req_in;
   logic [1:0] op_ff, op_in, cvt_ff, cvt_in;
   logic [TimeW-1:0] now_ff, now_in, key_ff, key_in, cls_ff, cls_in;
   logic [AW:0] scan_ff, scan_in;
   logic proc_vld_ff, proc_vld_in;
   logic [AW-1:0] proc_idx_ff, proc_idx_in, free_idx_ff, free_idx_in;
   logic dup_ff, dup_in, free_ok_ff, free_ok_in, found_ff, found_in;
   logic [TimeW-1:0] best_open_ff, best_open_in, best_close_ff, best_close_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [TimeW-1:0] pend_open_ff, pend_open_in, pend_close_ff, pend_close_in;
   logic [TimeW-1:0] close_at_ff, close_at_in, deadline_ff, deadline_in;
   logic close_armed_ff, close_armed_in, power_ff, power_in;
   logic [PulseW-1:0] drive_ff, drive_in, open_pw_ff, open_pw_in, close_pw_ff, close_pw_in;
   logic [HoldW-1:0] hold_ff, hold_in;
   logic [1:0] status_ff, status_in;
   logic opened_ff, opened_in, closed_ff, closed_in, rsp_valid_ff, rsp_valid_in;

   logic [TimeW-1:0] open_mem [QUEUE_DEPTH];
   logic [TimeW-1:0] close_mem [QUEUE_DEPTH];
   logic [TimeW-1:0] open_rd_ff, close_rd_ff;
   logic [AW-1:0] rd_addr;
   logic wr_en;

   logic [SecW-1:0] sel_s;
   logic [UsW-1:0] sel_us;
   logic [TimeW-1:0] cvt_val;

   always_comb begin
      case (cvt_ff)
         2'd0: begin
            sel_s  = req_ff[135:104];
            sel_us = req_ff[155:136];
         end
         2'd1: begin
            sel_s  = req_ff[31:0];
            sel_us = req_ff[51:32];
         end
         default: begin
            sel_s  = req_ff[83:52];
            sel_us = req_ff[103:84];
         end
      endcase
      cvt_val = TimeW'({20'd0, sel_s} * US_PER_S) + {32'd0, sel_us};
   end

   assign rd_addr = scan_ff[AW-1:0];
   assign wr_en   = (state_ff == S_COMMIT) && !dup_ff && free_ok_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         open_mem[free_idx_ff]  <= key_ff;
         close_mem[free_idx_ff] <= cls_ff;
      end
      open_rd_ff  <= open_mem[rd_addr];
      close_rd_ff <= close_mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      op_in = op_ff;
      cvt_in = cvt_ff;
      now_in = now_ff;
      key_in = key_ff;
      cls_in = cls_ff;
      scan_in = scan_ff;
      proc_vld_in = 1'b0;
      proc_idx_in = proc_idx_ff;
      free_idx_in = free_idx_ff;
      dup_in = dup_ff;
      free_ok_in = free_ok_ff;
      found_in = found_ff;
      best_open_in = best_open_ff;
      best_close_in = best_close_ff;
      valid_in = valid_ff;
      cnt_in = cnt_ff;
      pend_open_in = pend_open_ff;
      pend_close_in = pend_close_ff;
      close_at_in = close_at_ff;
      deadline_in = deadline_ff;
      close_armed_in = close_armed_ff;
      power_in = power_ff;
      drive_in = drive_ff;
      open_pw_in = open_pw_ff;
      close_pw_in = close_pw_ff;
      hold_in = hold_ff;
      status_in = status_ff;
      opened_in = opened_ff;
      closed_in = closed_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_we) begin
         case (csr_index)
            REG_OPEN_PULSE:  open_pw_in = csr_wdata[PulseW-1:0];
            REG_CLOSE_PULSE: close_pw_in = csr_wdata[PulseW-1:0];
            REG_POWER_HOLD:  hold_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               req_in = req_tdata[155:0];
               op_in = req_tuser;
               cvt_in = 2'd0;
               status_in = ST_OK;
               opened_in = 1'b0;
               closed_in = 1'b0;
               state_in = S_CVT;
            end
         end
         S_CVT: begin
            case (cvt_ff)
               2'd0: now_in = cvt_val;
               2'd1: key_in = cvt_val;
               default: cls_in = cvt_val;
            endcase
            cvt_in = cvt_ff + 2'd1;
            if (cvt_ff == 2'd2) begin
               scan_in = '0;
               dup_in = 1'b0;
               free_ok_in = 1'b0;
               found_in = 1'b0;
               case (op_ff)
                  OP_ADD: state_in = S_SCAN;
                  OP_TICK: state_in = S_OPEN;
                  OP_CLEAR: begin
                     valid_in = '0;
                     cnt_in = '0;
                     pend_open_in = '0;
                     pend_close_in = '0;
                     close_armed_in = 1'b0;
                     rsp_valid_in = 1'b1;
                     state_in = S_RESP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_OPEN: begin
            if (pend_open_ff != '0 && now_ff >= pend_open_ff) begin
               opened_in = 1'b1;
               pend_open_in = '0;
               power_in = 1'b1;
               drive_in = open_pw_ff;
               deadline_in = now_ff + TimeW'(hold_ff);
               close_armed_in = 1'b1;
               close_at_in = pend_close_ff;
               state_in = S_SCAN;
            end else begin
               state_in = S_CLOSE;
            end
         end
         S_SCAN: begin
            if (scan_ff < (AW+1)'(QUEUE_DEPTH)) begin
               proc_vld_in = 1'b1;
               proc_idx_in = scan_ff[AW-1:0];
               scan_in = scan_ff + 1'b1;
            end
            if (proc_vld_ff) begin
               if (op_ff == OP_ADD) begin
                  if (valid_ff[proc_idx_ff]) begin
                     if (open_rd_ff == key_ff) dup_in = 1'b1;
                     if (!found_ff || open_rd_ff < best_open_ff) begin
                        found_in = 1'b1;
                        best_open_in = open_rd_ff;
                        best_close_in = close_rd_ff;
                     end
                  end else if (!free_ok_ff) begin
                     free_ok_in = 1'b1;
                     free_idx_in = proc_idx_ff;
                  end
               end else if (valid_ff[proc_idx_ff]) begin
                  if (open_rd_ff <= now_ff) begin
                     valid_in[proc_idx_ff] = 1'b0;
                     cnt_in = cnt_ff - 1'b1;
                  end else if (!found_ff || open_rd_ff < best_open_ff) begin
                     found_in = 1'b1;
                     best_open_in = open_rd_ff;
                     best_close_in = close_rd_ff;
                  end
               end
            end else if (scan_ff == (AW+1)'(QUEUE_DEPTH)) begin
               state_in = (op_ff == OP_ADD) ? S_COMMIT : S_REARM;
            end
         end
         S_COMMIT: begin
            if (dup_ff) begin
               status_in = ST_DUP;
            end else if (!free_ok_ff) begin
               status_in = ST_FULL;
            end else begin
               valid_in[free_idx_ff] = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (!found_ff || key_ff < best_open_ff) begin
                  found_in = 1'b1;
                  best_open_in = key_ff;
                  best_close_in = cls_ff;
               end
            end
            state_in = S_REARM;
         end
         S_REARM: begin
            if (found_ff && best_open_ff > now_ff && best_open_ff != pend_open_ff) begin
               if (pend_close_ff == '0 || best_close_ff > pend_close_ff ||
                   best_open_ff < pend_open_ff) begin
                  pend_close_in = best_close_ff;
               end
               pend_open_in = best_open_ff;
            end
            if (op_ff == OP_TICK) begin
               state_in = S_CLOSE;
            end else begin
               rsp_valid_in = 1'b1;
               state_in = S_RESP;
            end
         end
         S_CLOSE: begin
            if (close_armed_ff && now_ff >= close_at_ff) begin
               closed_in = 1'b1;
               close_armed_in = 1'b0;
               power_in = 1'b1;
               drive_in = close_pw_ff;
               deadline_in = now_ff + TimeW'(hold_ff);
            end
            state_in = S_POWER;
         end
         S_POWER: begin
            if (power_ff && now_ff >= deadline_ff) power_in = 1'b0;
            rsp_valid_in = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cvt_ff <= '0;
         scan_ff <= '0;
         proc_vld_ff <= 1'b0;
         valid_ff <= '0;
         cnt_ff <= '0;
         pend_open_ff <= '0;
         pend_close_ff <= '0;
         close_at_ff <= '0;
         deadline_ff <= '0;
         close_armed_ff <= 1'b0;
         power_ff <= 1'b0;
         drive_ff <= '0;
         open_pw_ff <= OPEN_PULSE_RST;
         close_pw_ff <= CLOSE_PULSE_RST;
         hold_ff <= HOLD_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cvt_ff <= cvt_in;
         scan_ff <= scan_in;
         proc_vld_ff <= proc_vld_in;
         valid_ff <= valid_in;
         cnt_ff <= cnt_in;
         pend_open_ff <= pend_open_in;
         pend_close_ff <= pend_close_in;
         close_at_ff <= close_at_in;
         deadline_ff <= deadline_in;
         close_armed_ff <= close_armed_in;
         power_ff <= power_in;
         drive_ff <= drive_in;
         open_pw_ff <= open_pw_in;
         close_pw_ff <= close_pw_in;
         hold_ff <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      op_ff <= op_in;
      now_ff <= now_in;
      key_ff <= key_in;
      cls_ff <= cls_in;
      proc_idx_ff <= proc_idx_in;
      free_idx_ff <= free_idx_in;
      dup_ff <= dup_in;
      free_ok_ff <= free_ok_in;
      found_ff <= found_in;
      best_open_ff <= best_open_in;
      best_close_ff <= best_close_in;
      status_ff <= status_in;
      opened_ff <= opened_in;
      closed_ff <= closed_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {2'b00, pend_open_ff, CountW'(cnt_ff), drive_ff, power_ff,
                        closed_ff, opened_ff};

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while response pending");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count over depth");
   a_status_add: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> !opened_ff && !closed_ff)
      else $error("add status with fired action");
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && op_ff == OP_CLEAR |-> cnt_ff == '0 && pend_open_ff == '0)
      else $error("clear left entries");

endmodule
